/* hw/rtl/mlst_pkg.sv */
// shared constants, types and helpers for the mac learning table
package mlst_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int NUM_PORTS   = 8;
  localparam int MAC_W       = 48;
  localparam int PORT_W      = 3;
  localparam int MASK_W      = 8;

  localparam logic [MAC_W-1:0]  BCAST_MAC = {MAC_W{1'b1}};
  localparam logic [MASK_W-1:0] ALL_PORTS =
    (NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << NUM_PORTS) - 1);

  // item travelling down the chain, with what it has found so far
  typedef struct packed {
    logic              valid;
    logic [MAC_W-1:0]  dmac;
    logic [MAC_W-1:0]  smac;
    logic [PORT_W-1:0] port;
    logic              src_done;
    logic              learned;
    logic              dst_done;
    logic [PORT_W-1:0] dst_port;
  } query_t;

  function automatic logic port_exists(input logic [PORT_W-1:0] p);
    return int'(p) < NUM_PORTS;
  endfunction

  function automatic logic [MASK_W-1:0] port_bit(input logic [PORT_W-1:0] p);
    return MASK_W'(1) << p;
  endfunction

endpackage

/* hw/rtl/mlst_if.sv */
// valid/ready channels for frame headers and forwarding results
interface mlst_in_if import mlst_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MAC_W-1:0]  dest_mac;
  logic [MAC_W-1:0]  source_mac;
  logic [PORT_W-1:0] recv_port;

  modport source (output valid, output dest_mac, output source_mac, output recv_port,
                  input ready);
  modport sink   (input valid, input dest_mac, input source_mac, input recv_port,
                  output ready);
endinterface

interface mlst_out_if import mlst_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] port_mask;
  logic              flooded;
  logic              learned;
  logic              learn_dropped;

  modport source (output valid, output port_mask, output flooded, output learned,
                  output learn_dropped, input ready);
  modport sink   (input valid, input port_mask, input flooded, input learned,
                  input learn_dropped, output ready);
endinterface

/* hw/rtl/mlst_cell.sv */
// one table slot plus the chain register that hands the item to the next slot
module mlst_cell import mlst_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   advance,
  input  query_t q_in,
  output query_t q_out
);

  logic              ent_valid_r;
  logic [MAC_W-1:0]  ent_mac_r;
  logic [PORT_W-1:0] ent_port_r;
  query_t            q_r;
  query_t            q_nxt;

  logic              src_hit;
  logic              alloc;
  logic              eff_valid;
  logic [MAC_W-1:0]  eff_mac;
  logic [PORT_W-1:0] eff_port;
  logic              dst_hit;
  logic              upd;

  // slots fill from the bottom and are never freed, so the first empty
  // slot an unmatched item meets is the lowest free one
  assign src_hit = q_in.valid && !q_in.src_done && ent_valid_r && (ent_mac_r == q_in.smac);
  assign alloc   = q_in.valid && !q_in.src_done && !ent_valid_r;
  assign upd     = advance && (src_hit || alloc);

  // destination sees the slot after this item's own learning
  assign eff_valid = ent_valid_r || alloc;
  assign eff_mac   = alloc ? q_in.smac : ent_mac_r;
  assign eff_port  = (src_hit || alloc) ? q_in.port : ent_port_r;
  assign dst_hit   = !q_in.dst_done && eff_valid && (eff_mac == q_in.dmac)
                     && (q_in.dmac != BCAST_MAC);

  always_comb begin
    q_nxt = q_in;
    if (src_hit || alloc) begin
      q_nxt.src_done = 1'b1;
      q_nxt.learned  = alloc || (ent_port_r != q_in.port);
    end
    if (dst_hit) begin
      q_nxt.dst_done = 1'b1;
      q_nxt.dst_port = eff_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else if (advance && alloc) begin
      ent_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      ent_mac_r  <= eff_mac;
      ent_port_r <= q_in.port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (advance) begin
      q_r <= q_nxt;
    end
  end

  assign q_out = q_r;

endmodule

/* hw/rtl/mlst_result.sv */
// forwarding decision and output register at the end of the chain
module mlst_result import mlst_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  query_t q_in,
  output logic   advance,
  mlst_out_if.source out_chan
);

  logic              out_valid_r;
  logic [MASK_W-1:0] mask_r;
  logic              flooded_r;
  logic              learned_r;
  logic              dropped_r;
  logic [MASK_W-1:0] mask_nxt;

  assign advance = !out_valid_r || out_chan.ready;

  always_comb begin
    if (!q_in.dst_done) begin
      mask_nxt = ALL_PORTS;
      if (port_exists(q_in.port)) begin
        mask_nxt = mask_nxt & ~port_bit(q_in.port);
      end
    end else if (port_exists(q_in.dst_port)) begin
      mask_nxt = port_bit(q_in.dst_port);
    end else begin
      mask_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= q_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_in.valid) begin
      mask_r    <= mask_nxt;
      flooded_r <= !q_in.dst_done;
      learned_r <= q_in.learned;
      dropped_r <= !q_in.src_done;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.port_mask     = mask_r;
  assign out_chan.flooded       = flooded_r;
  assign out_chan.learned       = learned_r;
  assign out_chan.learn_dropped = dropped_r;

endmodule

/* hw/rtl/mac_learning_switch_table.sv */
// mac learning table: each item walks a chain of 64 slot cells, one cell per cycle
// each item loads into cell 0 when accepted, passes through every further cell in turn,
// and ends in the output register of the result stage
// throughput: one item per cycle while the output takes results; items keep their order
// the whole chain holds while a finished result waits at the output
// reset (rst_n low, synchronous): all slot valid flags clear and the table empties
module mac_learning_switch_table import mlst_pkg::*; (
  input logic clk,
  input logic rst_n,
  mlst_in_if.sink    in_chan,
  mlst_out_if.source out_chan
);

  query_t link [TABLE_DEPTH+1];
  logic   advance;

  always_comb begin
    link[0]          = '0;
    link[0].valid    = in_chan.valid;
    link[0].dmac     = in_chan.dest_mac;
    link[0].smac     = in_chan.source_mac;
    link[0].port     = in_chan.recv_port;
  end

  // no item is taken while reset is held
  assign in_chan.ready = advance && rst_n;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    mlst_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .q_in    (link[i]),
      .q_out   (link[i+1])
    );
  end

  mlst_result u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_in     (link[TABLE_DEPTH]),
    .advance  (advance),
    .out_chan (out_chan)
  );

endmodule

/* bench/mlst_fwd_checker.sv */
// checker for the mac learning table: watches both channels, predicts forwarding, compares
`timescale 1ns / 1ps

module mlst_fwd_checker import mlst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  mlst_in_if   in_mon,
  mlst_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [MASK_W-1:0] port_mask;
    logic              flooded;
    logic              learned;
    logic              learn_dropped;
  } fwd_result_t;

  // shadow of the station table
  logic              stn_used [TABLE_DEPTH];
  logic [MAC_W-1:0]  stn_mac  [TABLE_DEPTH];
  logic [PORT_W-1:0] stn_port [TABLE_DEPTH];

  fwd_result_t fwd_due[$];

  initial begin
    fail_count = 0;
    pending = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      stn_used[i] = 1'b0;
      stn_mac[i]  = '0;
      stn_port[i] = '0;
    end
  end

  function automatic int find_station(input logic [MAC_W-1:0] mac);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (stn_used[i] && stn_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  function automatic fwd_result_t learn_and_forward(input logic [MAC_W-1:0] dmac,
                                                    input logic [MAC_W-1:0] smac,
                                                    input logic [PORT_W-1:0] rport);
    fwd_result_t res;
    int hit;
    int slot;
    res = '0;
    slot = -1;
    hit = find_station(smac);
    if (hit >= 0) begin
      if (stn_port[hit] != rport) begin
        stn_port[hit] = rport;
        res.learned = 1'b1;
      end
    end else begin
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
        if (!stn_used[i]) slot = i;
      end
      if (slot >= 0) begin
        stn_used[slot] = 1'b1;
        stn_mac[slot]  = smac;
        stn_port[slot] = rport;
        res.learned = 1'b1;
      end else begin
        res.learn_dropped = 1'b1;
      end
    end

    hit = (dmac == BCAST_MAC) ? -1 : find_station(dmac);
    if (hit < 0) begin
      // flood everywhere but the arrival port
      for (int p = 0; p < MASK_W; p++) begin
        res.port_mask[p] = (p < NUM_PORTS) && (p != int'(rport));
      end
      res.flooded = 1'b1;
    end else if (int'(stn_port[hit]) < NUM_PORTS && int'(stn_port[hit]) < MASK_W) begin
      res.port_mask[stn_port[hit]] = 1'b1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    fwd_result_t got;
    fwd_result_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        fwd_due.push_back(learn_and_forward(in_mon.dest_mac, in_mon.source_mac,
                                            in_mon.recv_port));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.port_mask     = out_mon.port_mask;
        got.flooded       = out_mon.flooded;
        got.learned       = out_mon.learned;
        got.learn_dropped = out_mon.learn_dropped;
        if (fwd_due.size() == 0) begin
          report_mismatch($sformatf("result with no item outstanding: %p", got));
        end else begin
          want = fwd_due.pop_front();
          if (got.port_mask !== want.port_mask)
            report_mismatch($sformatf("port_mask got %b want %b",
                                      got.port_mask, want.port_mask));
          if (got.flooded !== want.flooded)
            report_mismatch($sformatf("flooded got %b want %b", got.flooded, want.flooded));
          if (got.learned !== want.learned)
            report_mismatch($sformatf("learned got %b want %b", got.learned, want.learned));
          if (got.learn_dropped !== want.learn_dropped)
            report_mismatch($sformatf("learn_dropped got %b want %b",
                                      got.learn_dropped, want.learn_dropped));
        end
      end
    end
    pending <= fwd_due.size();
  end

endmodule

/* bench/tb_top.sv */
// top of the mac learning table bench: clock, reset, frame stimulus, sink stalls, verdict
`timescale 1ns / 1ps

module tb_top;
  import mlst_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int POOL_SIZE   = 112;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_cnt;
  logic stalls_on;
  logic gaps_on;
  int   hold_left;

  logic [MAC_W-1:0] mac_pool [POOL_SIZE];

  mlst_in_if  in_if ();
  mlst_out_if out_if ();

  mac_learning_switch_table u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  mlst_fwd_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side backpressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(99) < 25) begin
      out_if.ready <= 1'b0;
      hold_left <= ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 0);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[MAC_W-1:0];
  endfunction

  task automatic send_frame(input logic [MAC_W-1:0] dmac, input logic [MAC_W-1:0] smac,
                            input logic [PORT_W-1:0] rport);
    int gap;
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 70) gap = 0;
    else if (r < 92) gap = $urandom_range(3, 1);
    else gap = $urandom_range(60, 10);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.dest_mac   <= dmac;
    in_if.source_mac <= smac;
    in_if.recv_port  <= rport;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_frames(input int count, input int src_span);
    logic [MAC_W-1:0] dmac;
    logic [MAC_W-1:0] smac;
    int r;
    for (int n = 0; n < count; n++) begin
      // switch between idling and full-rate stretches
      if (n % 100 == 0) begin
        gaps_on   <= ($urandom_range(3) != 0);
        stalls_on <= ($urandom_range(3) != 0);
      end
      if (src_span > 40 && $urandom_range(9) == 0) smac = rand_mac();
      else smac = mac_pool[$urandom_range(src_span - 1, 0)];
      r = $urandom_range(99);
      if (r < 8) dmac = BCAST_MAC;
      else if (r < 20) dmac = rand_mac();
      else if (r < 30) dmac = smac;
      else dmac = mac_pool[$urandom_range(src_span + 7, 0)];
      send_frame(dmac, smac, PORT_W'($urandom_range(7)));
    end
  endtask

  initial begin
    logic [MAC_W-1:0] mac_a;
    logic [MAC_W-1:0] mac_b;
    logic [MAC_W-1:0] mac_c;
    logic [MAC_W-1:0] mac_d;
    cycle_cnt = 0;
    hold_left = 0;
    stalls_on = 1'b0;
    gaps_on = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.dest_mac = '0;
    in_if.source_mac = '0;
    in_if.recv_port = '0;
    out_if.ready = 1'b0;

    for (int i = 0; i < POOL_SIZE; i++) begin
      // every eighth address is a one-bit neighbor of the previous one
      if (i % 8 == 1) mac_pool[i] = mac_pool[i-1] ^ (48'h1 << $urandom_range(47, 0));
      else mac_pool[i] = rand_mac();
    end

    mac_a = 48'h02_11_22_33_44_55;
    mac_b = 48'h02_66_77_88_99_aa;
    mac_c = 48'h00_00_00_00_00_01;
    mac_d = 48'h00_00_00_00_00_02;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: learning, moves, known and unknown destinations, broadcast
    send_frame(BCAST_MAC, mac_a, 3'd0);
    send_frame(mac_a, mac_b, 3'd7);
    send_frame(mac_b, mac_a, 3'd0);
    send_frame(mac_b, mac_a, 3'd3);
    send_frame(mac_a, mac_a, 3'd5);
    send_frame('0, '0, 3'd2);
    send_frame(BCAST_MAC, BCAST_MAC, 3'd4);
    send_frame(mac_c, mac_d, 3'd6);
    send_frame(48'h00_00_00_00_00_03, mac_d, 3'd6);
    send_frame(mac_c, mac_c, 3'd1);
    send_frame(mac_a ^ 48'h80_00_00_00_00_00, mac_b, 3'd2);
    send_frame(mac_a ^ 48'h1, mac_b, 3'd2);
    send_frame(BCAST_MAC, mac_a, 3'd7);
    send_frame(mac_a, mac_b, 3'd7);
    for (int p = 0; p < 8; p++) begin
      send_frame(BCAST_MAC, 48'h0a_00_00_00_00_00 | p, PORT_W'(p));
    end

    // small address set first so the table keeps room, then overflow it
    random_frames(600, 40);
    in_if.valid <= 1'b0;
    wait_drained();
    random_frames(730, 100);
    in_if.valid <= 1'b0;

    wait_drained();
    repeat (80) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
